// ===== rtl/cfp_pkg.sv =====
// Package for the CRC-checked frame parser: entry and result types, error codes,
// CRC seeds and polynomials, byte-wide CRC update functions. No dependencies.
package cfp_pkg;

    localparam logic [7:0]  HCRC_SEED  = 8'h77;
    localparam logic [7:0]  HCRC_POLY  = 8'h8C;
    localparam logic [15:0] FCRC_SEED  = 16'h3692;
    localparam logic [15:0] FCRC_POLY  = 16'h8408;
    localparam logic [1:0]  LEN_HI_MASK = 2'h3;
    localparam logic [7:0]  START_RESET = 8'h55;
    localparam logic [9:0]  FRAME_MIN  = 10'd13;
    localparam logic [9:0]  POS_MAX    = 10'd1023;

    localparam int Q_AW    = 2;
    localparam int Q_DEPTH = 1 << Q_AW;

    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_SHORT     = 3'd1;
    localparam logic [2:0] ERR_START     = 3'd2;
    localparam logic [2:0] ERR_LENGTH    = 3'd3;
    localparam logic [2:0] ERR_HDR_CRC   = 3'd4;
    localparam logic [2:0] ERR_FRAME_CRC = 3'd5;

    // one classified byte, front to back
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       start_bad;   // offset zero and not the start marker
        logic       hdr_phase;   // offsets 0..2, both CRCs run
        logic       hcrc_chk;    // offset 3, header CRC byte
        logic       hf_en;       // offsets 4..10
        logic [2:0] hf_idx;
        logic       crc_body;    // frame CRC runs over this byte
        logic       trl_lo;      // trailer low byte
        logic       trl_hi;      // trailer high byte, frame CRC check
        logic [9:0] pos;
        logic [9:0] flen;        // frame length after this byte
    } entry_t;

    typedef struct packed {
        logic        frame_ok;
        logic [2:0]  err_code;
        logic [7:0]  src_addr;
        logic [7:0]  dst_addr;
        logic [15:0] seq_num;
        logic [7:0]  command_type;
        logic [7:0]  command_set;
        logic [7:0]  command_id;
        logic [9:0]  payload_bytes;
    } result_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] r;
        r = c ^ b;
        for (int k = 0; k < 8; k++)
        begin
            r = r[0] ? ((r >> 1) ^ HCRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            r = r[0] ? ((r >> 1) ^ FCRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

// ===== rtl/cfp_front.sv =====
// Front end: accepts buffer bytes, tracks position and frame length, classifies
// each byte for the back end. Holds the start_byte register. Depends on cfp_pkg.
module cfp_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [7:0]      cfg_wdata,
    input  logic            push,
    input  logic [7:0]      rx_byte,
    input  logic            buf_last,
    input  logic            q_full,
    output logic            full,
    output logic            q_wr_en,
    output cfp_pkg::entry_t q_wr_data
);
    import cfp_pkg::*;

    logic [7:0]  start_reg;
    logic [9:0]  pos_reg, pos_next;
    logic [9:0]  flen_reg, flen_next;
    logic [10:0] pos_p1, pos_p2, flen_w;
    logic        accept;

    assign full   = q_full;
    assign accept = push && !q_full;

    assign pos_p1 = {1'b0, pos_reg} + 11'd1;
    assign pos_p2 = {1'b0, pos_reg} + 11'd2;
    assign flen_w = {1'b0, flen_reg};

    always_comb
    begin
        flen_next = flen_reg;
        if (pos_reg == 10'd1)
        begin
            flen_next = {flen_reg[9:8], rx_byte};
        end
        else if (pos_reg == 10'd2)
        begin
            flen_next = {rx_byte[1:0] & LEN_HI_MASK, flen_reg[7:0]};
        end
        pos_next = (pos_reg < POS_MAX) ? pos_reg + 10'd1 : pos_reg;
    end

    always_comb
    begin
        q_wr_data.data      = rx_byte;
        q_wr_data.last      = buf_last;
        q_wr_data.start_bad = (pos_reg == 10'd0) && (rx_byte != start_reg);
        q_wr_data.hdr_phase = pos_reg < 10'd3;
        q_wr_data.hcrc_chk  = pos_reg == 10'd3;
        q_wr_data.hf_en     = pos_reg inside {[10'd4:10'd10]};
        q_wr_data.hf_idx    = 3'(pos_reg - 10'd4);
        // frame length is settled once past the header CRC byte
        q_wr_data.crc_body  = !q_wr_data.hdr_phase && (pos_p2 < flen_w);
        q_wr_data.trl_lo    = !q_wr_data.hdr_phase && (pos_p2 == flen_w);
        q_wr_data.trl_hi    = !q_wr_data.hdr_phase && (pos_p1 == flen_w);
        q_wr_data.pos       = pos_reg;
        q_wr_data.flen      = flen_next;
    end

    assign q_wr_en = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= START_RESET;
            pos_reg   <= '0;
            flen_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                start_reg <= cfg_wdata;
            end
            if (accept)
            begin
                if (buf_last)
                begin
                    pos_reg  <= '0;
                    flen_reg <= '0;
                end
                else
                begin
                    pos_reg  <= pos_next;
                    flen_reg <= flen_next;
                end
            end
        end
    end

endmodule

// ===== rtl/cfp_queue.sv =====
// Short queue of classified bytes between front and back end.
// Depends on cfp_pkg (entry_t, Q_AW, Q_DEPTH).
module cfp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  cfp_pkg::entry_t wr_data,
    output logic            full,
    input  logic            rd_en,
    output logic            rd_valid,
    output cfp_pkg::entry_t rd_data
);
    import cfp_pkg::*;

    entry_t          mem [Q_DEPTH];
    logic [Q_AW-1:0] wp_reg, rp_reg;
    logic [Q_AW:0]   cnt_reg;
    logic            do_wr, do_rd;

    assign full     = cnt_reg == (Q_AW + 1)'(Q_DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = mem[rp_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (do_rd)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/cfp_back.sv =====
// Back end: runs header and frame CRCs, collects header fields, forms the verdict
// and holds results in a two-entry output queue. Depends on cfp_pkg.
module cfp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             ent_valid,
    input  cfp_pkg::entry_t  ent,
    output logic             ent_take,
    input  logic             pop,
    output logic             empty,
    output cfp_pkg::result_t res
);
    import cfp_pkg::*;

    logic [7:0]  hcrc_reg, hcrc_next;
    logic [15:0] fcrc_reg, fcrc_next;
    logic [7:0]  trl_lo_reg;
    logic [7:0]  hf_reg [7];
    logic [2:0]  vrd_reg, vrd_next;   // bit0 start, bit1 header crc, bit2 frame crc
    logic        done_reg, done_next;

    result_t     oq [2];
    logic        oq_wp_reg, oq_rp_reg;
    logic [1:0]  oq_cnt_reg;
    logic        oq_full, oq_wr, oq_rd;

    result_t     res_new;
    logic [2:0]  err;
    logic [10:0] count, flen_w;

    assign oq_full  = oq_cnt_reg == 2'd2;
    assign ent_take = ent_valid && !(ent.last && oq_full);
    assign oq_wr    = ent_take && ent.last;
    assign oq_rd    = pop && (oq_cnt_reg != 2'd0);
    assign empty    = oq_cnt_reg == 2'd0;
    assign res      = oq[oq_rp_reg];

    always_comb
    begin
        hcrc_next = hcrc_reg;
        fcrc_next = fcrc_reg;
        vrd_next  = vrd_reg;
        done_next = done_reg;
        if (ent.start_bad)
        begin
            vrd_next[0] = 1'b1;
        end
        if (ent.hdr_phase)
        begin
            hcrc_next = crc8_byte(hcrc_reg, ent.data);
            fcrc_next = crc16_byte(fcrc_reg, ent.data);
        end
        else
        begin
            if (ent.hcrc_chk && (hcrc_reg != ent.data))
            begin
                vrd_next[1] = 1'b1;
            end
            if (ent.crc_body)
            begin
                fcrc_next = crc16_byte(fcrc_reg, ent.data);
            end
            else if (ent.trl_hi)
            begin
                if ({ent.data, trl_lo_reg} != fcrc_reg)
                begin
                    vrd_next[2] = 1'b1;
                end
                done_next = 1'b1;
            end
        end
    end

    assign count  = {1'b0, ent.pos} + 11'd1;
    assign flen_w = {1'b0, ent.flen};

    // first failing check wins
    always_comb
    begin
        if (count < {1'b0, FRAME_MIN})
        begin
            err = ERR_SHORT;
        end
        else if (vrd_next[0])
        begin
            err = ERR_START;
        end
        else if ((ent.flen < FRAME_MIN) || (flen_w > count) || !done_next)
        begin
            err = ERR_LENGTH;
        end
        else if (vrd_next[1])
        begin
            err = ERR_HDR_CRC;
        end
        else if (vrd_next[2])
        begin
            err = ERR_FRAME_CRC;
        end
        else
        begin
            err = ERR_OK;
        end
    end

    // header bytes are all in place whenever the frame passes
    always_comb
    begin
        res_new          = '0;
        res_new.err_code = err;
        if (err == ERR_OK)
        begin
            res_new.frame_ok      = 1'b1;
            res_new.src_addr      = hf_reg[0];
            res_new.dst_addr      = hf_reg[1];
            res_new.seq_num       = {hf_reg[2], hf_reg[3]};
            res_new.command_type  = hf_reg[4];
            res_new.command_set   = hf_reg[5];
            res_new.command_id    = hf_reg[6];
            res_new.payload_bytes = ent.flen - FRAME_MIN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ent_take && ent.hf_en)
        begin
            hf_reg[ent.hf_idx] <= ent.data;
        end
        if (oq_wr)
        begin
            oq[oq_wp_reg] <= res_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hcrc_reg   <= HCRC_SEED;
            fcrc_reg   <= FCRC_SEED;
            trl_lo_reg <= '0;
            vrd_reg    <= '0;
            done_reg   <= 1'b0;
            oq_wp_reg  <= 1'b0;
            oq_rp_reg  <= 1'b0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            if (ent_take)
            begin
                if (ent.last)
                begin
                    hcrc_reg   <= HCRC_SEED;
                    fcrc_reg   <= FCRC_SEED;
                    trl_lo_reg <= '0;
                    vrd_reg    <= '0;
                    done_reg   <= 1'b0;
                end
                else
                begin
                    hcrc_reg <= hcrc_next;
                    fcrc_reg <= fcrc_next;
                    vrd_reg  <= vrd_next;
                    done_reg <= done_next;
                    if (!ent.hdr_phase && !ent.crc_body && ent.trl_lo)
                    begin
                        trl_lo_reg <= ent.data;
                    end
                end
            end
            if (oq_wr)
            begin
                oq_wp_reg <= ~oq_wp_reg;
            end
            if (oq_rd)
            begin
                oq_rp_reg <= ~oq_rp_reg;
            end
            if (oq_wr && !oq_rd)
            begin
                oq_cnt_reg <= oq_cnt_reg + 2'd1;
            end
            else if (oq_rd && !oq_wr)
            begin
                oq_cnt_reg <= oq_cnt_reg - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/crc_checked_frame_parser_unit.sv =====
// Frame check unit: one byte per cycle sustained while full is low, set by the byte-wide CRC update.
// Verdict path: the last byte is registered in the byte queue, then its verdict in the
// result queue, from which it can be popped, while no backlog is queued.
// Reset: start_byte returns to 0x55, position, CRC seeds, verdict and all queues
// clear at once; no clearing pass, bytes are taken from the first cycle.
module crc_checked_frame_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: start-of-frame marker
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    // byte input, queue style
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    input  logic        buf_last,
    // verdict output, queue style
    output logic        empty,
    input  logic        pop,
    output logic        frame_ok,
    output logic [2:0]  err_code,
    output logic [7:0]  src_addr,
    output logic [7:0]  dst_addr,
    output logic [15:0] seq_num,
    output logic [7:0]  command_type,
    output logic [7:0]  command_set,
    output logic [7:0]  command_id,
    output logic [9:0]  payload_bytes
);
    import cfp_pkg::*;

    // front -> queue
    logic    q_wr_en;
    entry_t  q_wr_data;
    logic    q_full;
    // queue -> back
    logic    ent_valid;
    entry_t  ent;
    logic    ent_take;
    result_t res;

    // Front: position counter, length capture, start check, per-byte classification.
    cfp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .rx_byte   (rx_byte),
        .buf_last  (buf_last),
        .q_full    (q_full),
        .full      (full),
        .q_wr_en   (q_wr_en),
        .q_wr_data (q_wr_data)
    );

    // Decoupling queue: lets the back end stall on a full result queue without
    // stopping the byte stream at once.
    cfp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_wr_en),
        .wr_data  (q_wr_data),
        .full     (q_full),
        .rd_en    (ent_take),
        .rd_valid (ent_valid),
        .rd_data  (ent)
    );

    // Back: CRC engines, header capture, verdict priority, result queue.
    cfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .ent_valid (ent_valid),
        .ent       (ent),
        .ent_take  (ent_take),
        .pop       (pop),
        .empty     (empty),
        .res       (res)
    );

    assign frame_ok      = res.frame_ok;
    assign err_code      = res.err_code;
    assign src_addr      = res.src_addr;
    assign dst_addr      = res.dst_addr;
    assign seq_num       = res.seq_num;
    assign command_type  = res.command_type;
    assign command_set   = res.command_set;
    assign command_id    = res.command_id;
    assign payload_bytes = res.payload_bytes;

`ifndef SYNTHESIS
    // a passing verdict always carries the ok code and vice versa
    a_ok_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (frame_ok == (err_code == ERR_OK)))
        else $error("frame_ok disagrees with err_code");

    // a failed frame reports no header fields
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !frame_ok) |-> (src_addr == 8'h00 && seq_num == 16'h0000 &&
                                   command_id == 8'h00 && payload_bytes == 10'd0))
        else $error("failed frame carries header fields");

    // a waiting verdict is not overwritten by later frames
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(err_code) && $stable(seq_num)))
        else $error("waiting verdict changed");
`endif

endmodule
